// ===== rtl/accel_tilt_to_color_levels_macros.svh =====
// Assertion helpers shared by the tilt-to-level RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ACCEL_TILT_TO_COLOR_LEVELS_MACROS_SVH
`define ACCEL_TILT_TO_COLOR_LEVELS_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ATCL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("atcl: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ATCL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("atcl: next-cycle check failed");

`endif

// ===== rtl/atcl_pkg.sv =====
`default_nettype none

package atcl_pkg;

  localparam int unsigned SAMPLE_BITS  = 16;
  localparam int unsigned LEVEL_BITS   = 8;
  localparam int unsigned AXES         = 3;

  // squares of sample magnitudes and their normalized form
  localparam int unsigned SQ_W         = 2 * SAMPLE_BITS;
  localparam int unsigned NORM_W       = 64;
  localparam int unsigned NORM_TOP     = 60;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned BYTE_GROUPS  = NORM_W / BYTE_W;
  localparam int unsigned SHIFT_W      = 5;

  // square root and rotation
  localparam int unsigned ROOT_STEPS   = NORM_W / 2;
  localparam int unsigned ROOT_W       = NORM_W / 2;
  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned STEP_IDX_W   = $clog2(CORDIC_STEPS);
  localparam int unsigned XY_W         = 36;
  localparam int unsigned ANGLE_W      = 27;

  // level = floor(angle * 25500 / (157 * 2^24))
  localparam int unsigned MUL_W        = 15;
  localparam int unsigned RECIP_W      = 24;
  localparam int unsigned DIV_W        = 32;
  localparam int unsigned LVL_SHIFT    = 40;
  localparam logic [MUL_W-1:0]   LVL_MUL   = MUL_W'(25500);
  localparam logic [RECIP_W-1:0] LVL_RECIP = RECIP_W'(10644382);
  localparam logic [DIV_W-1:0]   LVL_DIV   = DIV_W'(64'd2634022912);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
  } atcl_in_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level_x;
    logic [LEVEL_BITS-1:0] level_y;
    logic [LEVEL_BITS-1:0] level_z;
  } atcl_out_t;

  // arctangent of 2^-i in radians, 24 fractional bits, rounded to nearest
  function automatic logic signed [ANGLE_W-1:0] atan_q24(input logic [STEP_IDX_W-1:0] idx);
    logic signed [ANGLE_W-1:0] val;
    unique case (idx)
      5'd0:    val = ANGLE_W'(13176795);
      5'd1:    val = ANGLE_W'(7778716);
      5'd2:    val = ANGLE_W'(4110060);
      5'd3:    val = ANGLE_W'(2086331);
      5'd4:    val = ANGLE_W'(1047214);
      5'd5:    val = ANGLE_W'(524117);
      5'd6:    val = ANGLE_W'(262123);
      5'd7:    val = ANGLE_W'(131069);
      5'd8:    val = ANGLE_W'(65536);
      5'd9:    val = ANGLE_W'(32768);
      5'd10:   val = ANGLE_W'(16384);
      5'd11:   val = ANGLE_W'(8192);
      5'd12:   val = ANGLE_W'(4096);
      5'd13:   val = ANGLE_W'(2048);
      5'd14:   val = ANGLE_W'(1024);
      5'd15:   val = ANGLE_W'(512);
      5'd16:   val = ANGLE_W'(256);
      5'd17:   val = ANGLE_W'(128);
      5'd18:   val = ANGLE_W'(64);
      5'd19:   val = ANGLE_W'(32);
      5'd20:   val = ANGLE_W'(16);
      5'd21:   val = ANGLE_W'(8);
      5'd22:   val = ANGLE_W'(4);
      5'd23:   val = ANGLE_W'(2);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/atcl_prep.sv =====
`default_nettype none

module atcl_prep (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   vld_i,
  input  atcl_pkg::atcl_in_t                     data_i,
  output logic                                   vld_o,
  output logic [atcl_pkg::AXES-1:0]              pos_o,
  output logic [atcl_pkg::NORM_W-1:0]            v_o [atcl_pkg::AXES],
  output logic signed [atcl_pkg::XY_W-1:0]       y_o [atcl_pkg::AXES]
);
  import atcl_pkg::*;

  localparam int unsigned STAGES  = 6;
  localparam int unsigned P_W     = $clog2(NORM_W);
  localparam int unsigned GRP_W   = $clog2(BYTE_GROUPS);
  localparam int unsigned BIDX_W  = $clog2(BYTE_W);
  localparam int unsigned KD_W    = P_W + 1;

  logic [STAGES-1:0] vld_q;

  logic signed [SAMPLE_BITS-1:0] smp [AXES];

  logic [SAMPLE_BITS-1:0] mag0_d [AXES], mag0_q [AXES];
  logic [AXES-1:0]        pos0_d, pos0_q;

  logic [SQ_W-1:0]        sq1_d [AXES], sq1_q [AXES];
  logic [SAMPLE_BITS-1:0] mag1_q [AXES];
  logic [AXES-1:0]        pos1_q;

  logic [SQ_W-1:0]        s2_d [AXES], s2_q [AXES];
  logic [SQ_W-1:0]        m2_d [AXES], m2_q [AXES];
  logic [SAMPLE_BITS-1:0] am2_q [AXES];
  logic [AXES-1:0]        pos2_q;

  logic [BYTE_GROUPS-1:0] nz3_d [AXES], nz3_q [AXES];
  logic [BIDX_W-1:0]      loc3_d [AXES][BYTE_GROUPS], loc3_q [AXES][BYTE_GROUPS];
  logic [SQ_W-1:0]        s3_q [AXES];
  logic [SAMPLE_BITS-1:0] am3_q [AXES];
  logic [AXES-1:0]        pos3_q;

  logic [SHIFT_W-1:0]     k4_d [AXES], k4_q [AXES];
  logic [SQ_W-1:0]        s4_q [AXES];
  logic [SAMPLE_BITS-1:0] am4_q [AXES];
  logic [AXES-1:0]        pos4_q;

  logic [NORM_W-1:0]      v5_d [AXES], v5_q [AXES];
  logic signed [XY_W-1:0] y5_d [AXES], y5_q [AXES];
  logic [AXES-1:0]        pos5_q;

  assign smp[0] = data_i.accel_x;
  assign smp[1] = data_i.accel_y;
  assign smp[2] = data_i.accel_z;

  always_comb begin
    logic [SQ_W:0]     sum;
    logic [NORM_W-1:0] mx;
    logic [P_W-1:0]    p;
    logic [KD_W-1:0]   kd;
    int                o1;
    int                o2;
    for (int l = 0; l < AXES; l++) begin
      // magnitude and strictly-positive flag
      mag0_d[l] = smp[l][SAMPLE_BITS-1] ? SAMPLE_BITS'(~smp[l] + 1'b1)
                                        : SAMPLE_BITS'(smp[l]);
      pos0_d[l] = !smp[l][SAMPLE_BITS-1] && (smp[l] != '0);

      sq1_d[l] = SQ_W'(mag0_q[l]) * SQ_W'(mag0_q[l]);

      // radial part uses the other two axes
      o1 = (l == 0) ? 1 : 0;
      o2 = (l == 2) ? 1 : 2;
      sum = {1'b0, sq1_q[o1]} + {1'b0, sq1_q[o2]};
      s2_d[l] = sum[SQ_W-1:0];
      m2_d[l] = (sq1_q[l] > s2_d[l]) ? sq1_q[l] : s2_d[l];

      // per-byte leading one of the larger square
      mx = NORM_W'(m2_q[l]);
      for (int g = 0; g < BYTE_GROUPS; g++) begin
        nz3_d[l][g] = |mx[g*BYTE_W +: BYTE_W];
        loc3_d[l][g] = '0;
        for (int b = 0; b < BYTE_W; b++) begin
          if (mx[g*BYTE_W + b]) loc3_d[l][g] = BIDX_W'(b);
        end
      end

      // even shift that lifts the larger square to bit NORM_TOP or above
      p = '0;
      for (int g = 0; g < BYTE_GROUPS; g++) begin
        if (nz3_q[l][g]) p = {GRP_W'(g), loc3_q[l][g]};
      end
      kd = KD_W'(NORM_TOP + 1) - KD_W'(p);
      k4_d[l] = (p >= P_W'(NORM_TOP)) ? '0 : kd[SHIFT_W:1];

      v5_d[l] = NORM_W'(s4_q[l]) << {k4_q[l], 1'b0};
      y5_d[l] = XY_W'(am4_q[l]) << k4_q[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos0_q <= pos0_d;
      pos1_q <= pos0_q;
      pos2_q <= pos1_q;
      pos3_q <= pos2_q;
      pos4_q <= pos3_q;
      pos5_q <= pos4_q;
      for (int l = 0; l < AXES; l++) begin
        mag0_q[l] <= mag0_d[l];
        sq1_q[l]  <= sq1_d[l];
        mag1_q[l] <= mag0_q[l];
        s2_q[l]   <= s2_d[l];
        m2_q[l]   <= m2_d[l];
        am2_q[l]  <= mag1_q[l];
        nz3_q[l]  <= nz3_d[l];
        for (int g = 0; g < BYTE_GROUPS; g++) begin
          loc3_q[l][g] <= loc3_d[l][g];
        end
        s3_q[l]   <= s2_q[l];
        am3_q[l]  <= am2_q[l];
        k4_q[l]   <= k4_d[l];
        s4_q[l]   <= s3_q[l];
        am4_q[l]  <= am3_q[l];
        v5_q[l]   <= v5_d[l];
        y5_q[l]   <= y5_d[l];
      end
    end
  end

  assign vld_o = vld_q[STAGES-1];
  assign pos_o = pos5_q;
  assign v_o   = v5_q;
  assign y_o   = y5_q;

endmodule

`default_nettype wire

// ===== rtl/atcl_isqrt.sv =====
`default_nettype none

module atcl_isqrt (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               vld_i,
  input  logic [atcl_pkg::AXES-1:0]          pos_i,
  input  logic [atcl_pkg::NORM_W-1:0]        v_i [atcl_pkg::AXES],
  input  logic signed [atcl_pkg::XY_W-1:0]   y_i [atcl_pkg::AXES],
  output logic                               vld_o,
  output logic [atcl_pkg::AXES-1:0]          pos_o,
  output logic [atcl_pkg::ROOT_W-1:0]        root_o [atcl_pkg::AXES],
  output logic signed [atcl_pkg::XY_W-1:0]   y_o [atcl_pkg::AXES]
);
  import atcl_pkg::*;

  localparam int unsigned LAST = ROOT_STEPS - 1;

  logic                   vld_in [ROOT_STEPS];
  logic                   vld_q  [ROOT_STEPS];
  logic [AXES-1:0]        pos_in [ROOT_STEPS];
  logic [AXES-1:0]        pos_q  [ROOT_STEPS];
  logic [NORM_W-1:0]      rem_in [ROOT_STEPS][AXES];
  logic [NORM_W-1:0]      rem_d  [ROOT_STEPS][AXES];
  logic [NORM_W-1:0]      rem_q  [ROOT_STEPS][AXES];
  logic [NORM_W-1:0]      res_in [ROOT_STEPS][AXES];
  logic [NORM_W-1:0]      res_d  [ROOT_STEPS][AXES];
  logic [NORM_W-1:0]      res_q  [ROOT_STEPS][AXES];
  logic signed [XY_W-1:0] y_in   [ROOT_STEPS][AXES];
  logic signed [XY_W-1:0] y_q    [ROOT_STEPS][AXES];

  // one result bit per stage, most significant first
  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_step
    localparam logic [NORM_W-1:0] TRIAL_BIT = NORM_W'(1) << (NORM_W - 2 - 2 * j);

    if (j == 0) begin : g_src
      assign vld_in[j] = vld_i;
      assign pos_in[j] = pos_i;
      for (genvar l = 0; l < AXES; l++) begin : g_lane
        assign rem_in[j][l] = v_i[l];
        assign res_in[j][l] = '0;
        assign y_in[j][l]   = y_i[l];
      end
    end else begin : g_src
      assign vld_in[j] = vld_q[j-1];
      assign pos_in[j] = pos_q[j-1];
      for (genvar l = 0; l < AXES; l++) begin : g_lane
        assign rem_in[j][l] = rem_q[j-1][l];
        assign res_in[j][l] = res_q[j-1][l];
        assign y_in[j][l]   = y_q[j-1][l];
      end
    end

    always_comb begin
      logic [NORM_W-1:0] trial;
      for (int l = 0; l < AXES; l++) begin
        trial = res_in[j][l] + TRIAL_BIT;
        if (rem_in[j][l] >= trial) begin
          rem_d[j][l] = rem_in[j][l] - trial;
          res_d[j][l] = (res_in[j][l] >> 1) + TRIAL_BIT;
        end else begin
          rem_d[j][l] = rem_in[j][l];
          res_d[j][l] = res_in[j][l] >> 1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pos_q[j] <= pos_in[j];
        for (int l = 0; l < AXES; l++) begin
          rem_q[j][l] <= rem_d[j][l];
          res_q[j][l] <= res_d[j][l];
          y_q[j][l]   <= y_in[j][l];
        end
      end
    end
  end

  assign vld_o = vld_q[LAST];
  assign pos_o = pos_q[LAST];
  for (genvar l = 0; l < AXES; l++) begin : g_out
    assign root_o[l] = res_q[LAST][l][ROOT_W-1:0];
    assign y_o[l]    = y_q[LAST][l];
  end

endmodule

`default_nettype wire

// ===== rtl/atcl_cordic.sv =====
`default_nettype none

module atcl_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  logic [atcl_pkg::AXES-1:0]           pos_i,
  input  logic [atcl_pkg::ROOT_W-1:0]         root_i [atcl_pkg::AXES],
  input  logic signed [atcl_pkg::XY_W-1:0]    y_i [atcl_pkg::AXES],
  output logic                                vld_o,
  output logic [atcl_pkg::AXES-1:0]           pos_o,
  output logic signed [atcl_pkg::ANGLE_W-1:0] z_o [atcl_pkg::AXES]
);
  import atcl_pkg::*;

  localparam int unsigned LAST = CORDIC_STEPS - 1;

  logic                      vld_in [CORDIC_STEPS];
  logic                      vld_q  [CORDIC_STEPS];
  logic [AXES-1:0]           pos_in [CORDIC_STEPS];
  logic [AXES-1:0]           pos_q  [CORDIC_STEPS];
  logic signed [XY_W-1:0]    x_in   [CORDIC_STEPS][AXES];
  logic signed [XY_W-1:0]    x_d    [CORDIC_STEPS][AXES];
  logic signed [XY_W-1:0]    x_q    [CORDIC_STEPS][AXES];
  logic signed [XY_W-1:0]    y_in   [CORDIC_STEPS][AXES];
  logic signed [XY_W-1:0]    y_d    [CORDIC_STEPS][AXES];
  logic signed [XY_W-1:0]    y_q    [CORDIC_STEPS][AXES];
  logic signed [ANGLE_W-1:0] z_in   [CORDIC_STEPS][AXES];
  logic signed [ANGLE_W-1:0] z_d    [CORDIC_STEPS][AXES];
  logic signed [ANGLE_W-1:0] z_q    [CORDIC_STEPS][AXES];

  // arithmetic shift that rounds toward zero
  function automatic logic signed [XY_W-1:0] shr_tz(input logic signed [XY_W-1:0] v,
                                                    input int unsigned s);
    logic signed [XY_W-1:0] neg;
    neg = -v;
    return v[XY_W-1] ? -(neg >>> s) : (v >>> s);
  endfunction

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ANGLE_W-1:0] ATAN_I = atan_q24(STEP_IDX_W'(i));

    if (i == 0) begin : g_src
      assign vld_in[i] = vld_i;
      assign pos_in[i] = pos_i;
      for (genvar l = 0; l < AXES; l++) begin : g_lane
        assign x_in[i][l] = XY_W'(root_i[l]);
        assign y_in[i][l] = y_i[l];
        assign z_in[i][l] = '0;
      end
    end else begin : g_src
      assign vld_in[i] = vld_q[i-1];
      assign pos_in[i] = pos_q[i-1];
      for (genvar l = 0; l < AXES; l++) begin : g_lane
        assign x_in[i][l] = x_q[i-1][l];
        assign y_in[i][l] = y_q[i-1][l];
        assign z_in[i][l] = z_q[i-1][l];
      end
    end

    // rotate the vector toward the x axis, accumulate the angle
    always_comb begin
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      for (int l = 0; l < AXES; l++) begin
        dx = shr_tz(y_in[i][l], i);
        dy = shr_tz(x_in[i][l], i);
        if (y_in[i][l] > 0) begin
          x_d[i][l] = x_in[i][l] + dx;
          y_d[i][l] = y_in[i][l] - dy;
          z_d[i][l] = z_in[i][l] + ATAN_I;
        end else begin
          x_d[i][l] = x_in[i][l] - dx;
          y_d[i][l] = y_in[i][l] + dy;
          z_d[i][l] = z_in[i][l] - ATAN_I;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pos_q[i] <= pos_in[i];
        for (int l = 0; l < AXES; l++) begin
          x_q[i][l] <= x_d[i][l];
          y_q[i][l] <= y_d[i][l];
          z_q[i][l] <= z_d[i][l];
        end
      end
    end
  end

  assign vld_o = vld_q[LAST];
  assign pos_o = pos_q[LAST];
  assign z_o   = z_q[LAST];

endmodule

`default_nettype wire

// ===== rtl/atcl_scale.sv =====
`default_nettype none
`include "accel_tilt_to_color_levels_macros.svh"

module atcl_scale (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  logic [atcl_pkg::AXES-1:0]           pos_i,
  input  logic signed [atcl_pkg::ANGLE_W-1:0] z_i [atcl_pkg::AXES],
  output logic                                vld_o,
  output atcl_pkg::atcl_out_t                 data_o
);
  import atcl_pkg::*;

  localparam int unsigned ZC_W = ANGLE_W - 1;
  localparam int unsigned PK_W = ZC_W + RECIP_W;
  localparam int unsigned PT_W = ZC_W + MUL_W;
  localparam int unsigned Q_W  = PK_W - LVL_SHIFT;
  localparam int unsigned QD_W = Q_W + 1 + DIV_W;
  localparam logic [Q_W:0] LVL_MAX = (Q_W + 1)'((1 << LEVEL_BITS) - 1);

  logic                  vld1_q, vld2_q, vld3_q;
  logic [ZC_W-1:0]       zc [AXES];
  logic [PK_W-1:0]       pk1_q [AXES];
  logic [PT_W-1:0]       pt1_q [AXES];
  logic [Q_W-1:0]        q2_d [AXES], q2_q [AXES];
  logic [QD_W-1:0]       qd2_d [AXES], qd2_q [AXES];
  logic [PT_W-1:0]       pt2_q [AXES];
  logic [LEVEL_BITS-1:0] lvl3_d [AXES], lvl3_q [AXES];

  always_comb begin
    logic [Q_W:0] qf;
    for (int l = 0; l < AXES; l++) begin
      // clamp negative angles and non-positive axes to zero
      zc[l] = (pos_i[l] && !z_i[l][ANGLE_W-1]) ? z_i[l][ZC_W-1:0] : '0;

      // reciprocal estimate, low by at most one
      q2_d[l]  = pk1_q[l][LVL_SHIFT +: Q_W];
      qd2_d[l] = QD_W'({1'b0, q2_d[l]} + 1'b1) * QD_W'(LVL_DIV);

      qf = {1'b0, q2_q[l]} + (Q_W + 1)'(QD_W'(pt2_q[l]) >= qd2_q[l]);
      lvl3_d[l] = (qf > LVL_MAX) ? LVL_MAX[LEVEL_BITS-1:0] : qf[LEVEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < AXES; l++) begin
        pk1_q[l]  <= PK_W'(zc[l]) * PK_W'(LVL_RECIP);
        pt1_q[l]  <= PT_W'(zc[l]) * PT_W'(LVL_MUL);
        q2_q[l]   <= q2_d[l];
        qd2_q[l]  <= qd2_d[l];
        pt2_q[l]  <= pt1_q[l];
        lvl3_q[l] <= lvl3_d[l];
      end
    end
  end

  assign vld_o          = vld3_q;
  assign data_o.level_x = lvl3_q[0];
  assign data_o.level_y = lvl3_q[1];
  assign data_o.level_z = lvl3_q[2];

  // the estimate q satisfies q*D <= t < (q+2)*D
  `ATCL_ASSERT_NOW(a_est_not_high, vld2_q,
                   (QD_W'(pt2_q[0]) + QD_W'(LVL_DIV) >= qd2_q[0]))
  `ATCL_ASSERT_NOW(a_est_not_low, vld2_q,
                   (QD_W'(pt2_q[1]) < qd2_q[1] + QD_W'(LVL_DIV)))
  `ATCL_ASSERT_NEXT(a_nonpos_zero, (en_i && vld_i && !pos_i[2]),
                    (vld1_q && pt1_q[2] == '0))

endmodule

`default_nettype wire

// ===== rtl/accel_tilt_to_color_levels.sv =====
// Accelerometer tilt to color levels.
// Input channel: in_valid_i / in_ready_o carry one signed sample triple
// (accel_x, accel_y, accel_z) per transfer. Output channel: out_valid_o /
// out_ready_i carry one result with an 8-bit level per axis: the tilt
// angle of that axis against the plane of the other two, 0..90 degrees
// mapped to 0..255; non-positive angles give 0.
// Throughput: one transfer per cycle on each side while the output is not
// stalled. Path from input transfer to output valid: squaring and
// normalization, 32 square root stages, 24 rotation stages, level scaling.
// Reset clears every stage valid bit; the pipeline is empty afterwards and
// in_ready_o is high. All three axes share one stall enable: while a result
// sits at the output and out_ready_i is low, every stage holds and
// in_ready_o drops; bubbles in the pipeline do not block a new input.
`default_nettype none

module accel_tilt_to_color_levels (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  atcl_pkg::atcl_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output atcl_pkg::atcl_out_t out_data_o
);
  import atcl_pkg::*;

  logic                      en;
  logic                      prep_vld, root_vld, rot_vld;
  logic [AXES-1:0]           prep_pos, root_pos, rot_pos;
  logic [NORM_W-1:0]         prep_v [AXES];
  logic signed [XY_W-1:0]    prep_y [AXES];
  logic [ROOT_W-1:0]         root [AXES];
  logic signed [XY_W-1:0]    root_y [AXES];
  logic signed [ANGLE_W-1:0] angle [AXES];

  // advance everything unless the output register is full and stalled
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  atcl_prep u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .data_i (in_data_i),
    .vld_o  (prep_vld),
    .pos_o  (prep_pos),
    .v_o    (prep_v),
    .y_o    (prep_y)
  );

  atcl_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (prep_vld),
    .pos_i  (prep_pos),
    .v_i    (prep_v),
    .y_i    (prep_y),
    .vld_o  (root_vld),
    .pos_o  (root_pos),
    .root_o (root),
    .y_o    (root_y)
  );

  atcl_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (root_vld),
    .pos_i  (root_pos),
    .root_i (root),
    .y_i    (root_y),
    .vld_o  (rot_vld),
    .pos_o  (rot_pos),
    .z_o    (angle)
  );

  atcl_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (rot_vld),
    .pos_i  (rot_pos),
    .z_i    (angle),
    .vld_o  (out_valid_o),
    .data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import atcl_pkg::*;

  localparam int LATENCY = 65;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  atcl_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  atcl_out_t out_data_o;

  accel_tilt_to_color_levels dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  atcl_in_t  sample_q[$];
  atcl_out_t level_q[$];
  int        send_idle_pct;
  int        recv_stall_pct;
  int        errors;
  int        sent;
  int        received;

  // arctangent of 2^-i, radians with 24 fractional bits
  localparam longint ATAN_TBL[24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // shift right, rounding toward zero
  function automatic longint trunc_shr(longint v, int s);
    longint unsigned m;
    if (v >= 0) return longint'(longint'(v) >>> s);
    m = longint'(-v);
    return -longint'(m >> s);
  endfunction

  function automatic logic [7:0] axis_level(longint a, longint b, longint c);
    longint unsigned am, sq_a, rad, big, lvl;
    longint x, y, z, dx, dy;
    int k;
    if (a <= 0) return 8'd0;
    am   = a;
    sq_a = am * am;
    rad  = longint'(b * b) + longint'(c * c);
    big  = sq_a > rad ? sq_a : rad;
    k    = 0;
    while (big < (64'd1 << 60)) begin
      big = big << 2;
      k++;
    end
    x = floor_sqrt(rad << (2 * k));
    y = am << k;
    z = 0;
    for (int i = 0; i < 24; i++) begin
      dx = trunc_shr(y, i);
      dy = trunc_shr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end
    end
    if (z < 0) z = 0;
    lvl = (longint'(z) * 64'd25500) / (64'd157 << 24);
    return lvl > 255 ? 8'd255 : lvl[7:0];
  endfunction

  function automatic atcl_out_t tilt_levels(atcl_in_t s);
    atcl_out_t r;
    longint ax, ay, az;
    ax = s.accel_x;
    ay = s.accel_y;
    az = s.accel_z;
    r.level_x = axis_level(ax, ay, az);
    r.level_y = axis_level(ay, ax, az);
    r.level_z = axis_level(az, ay, ax);
    return r;
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0:       return 16'(32767 - $urandom_range(0, 3));
      1:       return 16'(-32768 + $urandom_range(0, 3));
      2:       return 16'($urandom_range(0, 8) - 4);
      3:       return 16'($signed($urandom_range(0, 8191)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    atcl_in_t s;
    s.accel_x = x;
    s.accel_y = y;
    s.accel_z = z;
    sample_q.push_back(s);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        level_q.push_back(tilt_levels(in_data_i));
        sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (sample_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= sample_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    atcl_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        received++;
        if (level_q.size() == 0) begin
          $display("%0t: result with nothing pending: %h", $time, out_data_o);
          errors++;
        end else begin
          want = level_q.pop_front();
          if (want.level_x !== out_data_o.level_x) begin
            $display("%0t: level_x expected %0d actual %0d", $time, want.level_x,
                     out_data_o.level_x);
            errors++;
          end
          if (want.level_y !== out_data_o.level_y) begin
            $display("%0t: level_y expected %0d actual %0d", $time, want.level_y,
                     out_data_o.level_y);
            errors++;
          end
          if (want.level_z !== out_data_o.level_z) begin
            $display("%0t: level_z expected %0d actual %0d", $time, want.level_z,
                     out_data_o.level_z);
            errors++;
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int phase_idle[4];
    int phase_stall[4];
    phase_idle  = '{0, 74, 0, 20};
    phase_stall = '{0, 0, 74, 20};
    errors = 0;
    sent = 0;
    received = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes, zero, on-axis and mixed-sign triples
    add_sample(16'd0, 16'd0, 16'd0);
    add_sample(16'h7fff, 16'd0, 16'd0);
    add_sample(16'd0, 16'h7fff, 16'd0);
    add_sample(16'd0, 16'd0, 16'h7fff);
    add_sample(16'h8000, 16'h8000, 16'h8000);
    add_sample(16'h7fff, 16'h7fff, 16'h7fff);
    add_sample(16'h8000, 16'h7fff, 16'h0001);
    add_sample(16'd1, 16'd0, 16'd0);
    add_sample(16'd1, 16'd1, 16'd1);
    add_sample(16'hffff, 16'hffff, 16'hffff);
    add_sample(16'd4096, 16'd0, 16'hf000);
    add_sample(16'd1, 16'h7fff, 16'h8000);
    add_sample(16'h7fff, 16'd1, 16'hffff);
    add_sample(16'd2896, 16'd2896, 16'd4096);
    add_sample(16'h5555, 16'haaaa, 16'h5555);
    add_sample(16'haaaa, 16'h5555, 16'haaaa);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      for (int n = 0; n < 475; n++) add_sample(rand_axis(), rand_axis(), rand_axis());
      // hold until the driver has sent every queued triple of this phase
      wait (sample_q.size() == 0 && !in_valid_i);
    end
    wait (level_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("Sent %0d sample triples over four handshake phases, checked %0d results.",
             sent, received);
    if (errors == 0 && level_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/atcl_pkg.sv
rtl/atcl_prep.sv
rtl/atcl_isqrt.sv
rtl/atcl_cordic.sv
rtl/atcl_scale.sv
rtl/accel_tilt_to_color_levels.sv
tb/sv/testbench.sv
